// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ----- hw/rtl/crfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfd_pkg
// Shared constants, types and the saturation helper of the complex IIR filter.
// ----------------------------------------------------------------------------
package crfd_pkg;
   localparam int MAX_ORDER_DEF   = 8;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 24;
   localparam int DELAY_BITS      = 40;
   localparam int OUT_BITS        = 24;

   localparam logic [1:0] CSR_ORDER = 2'd0;
   localparam logic [1:0] CSR_HOP   = 2'd1;
   localparam logic [1:0] CSR_EMIT  = 2'd2;

   typedef enum logic {FUNC_LOAD = 1'b0, FUNC_SAMPLE = 1'b1} func_type;
   typedef enum logic {KIND_B = 1'b0, KIND_A = 1'b1} kind_type;

   // Saturate a 64-bit value to the delay width.
   function automatic logic signed [DELAY_BITS-1:0] sat_delay(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (DELAY_BITS - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) sat_delay = hi[DELAY_BITS-1:0];
      else if (v < lo) sat_delay = lo[DELAY_BITS-1:0];
      else sat_delay = v[DELAY_BITS-1:0];
   endfunction
endpackage

// ----- hw/rtl/complex_recursive_filter_decimating.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_recursive_filter_decimating
// Complex IIR filter, transposed direct form II, with decimation by hop.
// ----------------------------------------------------------------------------
// channel | direction | contents
// req     | in        | func, coef_kind, coef_index, coefficients, sample
// rsp     | out       | filtered sample, clip flag, count
// csr     | in        | register index and value
// A load word writes its coefficient. A sample word is handled in two steps: the
// first forms y through the b0 multipliers and the head cell's delay, the second
// updates the cells up to the order from y. Reset clears coefficients, delays
// and counters. A waiting result holds the block; it accepts again once rsp is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module complex_recursive_filter_decimating #(
   parameter int MAX_ORDER   = crfd_pkg::MAX_ORDER_DEF,
   parameter int SAMPLE_BITS = crfd_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = crfd_pkg::COEF_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: coef_index, coef_re, coef_im, sample_re, sample_im (padded)
   input  logic [((4 + 2*COEF_BITS + 2*SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: func, coef_kind
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: out_re, out_im, processed_count
   output logic [79:0] rsp_tdata,
   // tuser: saturated
   output logic rsp_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);
   localparam int FRAC_S = SAMPLE_BITS - 1;
   localparam int FRAC_C = COEF_BITS - 4;
   localparam int PW     = COEF_BITS + SAMPLE_BITS;
   localparam int DB     = crfd_pkg::DELAY_BITS;
   localparam int OB     = crfd_pkg::OUT_BITS;
   localparam int C0     = 4;
   localparam int C1     = C0 + COEF_BITS;
   localparam int S0     = C1 + COEF_BITS;
   localparam int S1     = S0 + SAMPLE_BITS;

   logic [3:0]  order_ff;
   logic [15:0] hop_ff;
   logic        emit_all_ff;
   logic [31:0] count_ff;
   logic [15:0] phase_ff;
   logic        busy_ff;
   logic signed [SAMPLE_BITS-1:0] x_re_ff, x_im_ff;
   logic signed [OB-1:0] y_re_ff, y_im_ff;
   logic        rsp_valid_ff;
   logic [79:0] rsp_data_ff;
   logic        rsp_user_ff;

   wire  [3:0] idx = req_tdata[3:0];
   wire  signed [COEF_BITS-1:0] c_re = req_tdata[C1-1:C0];
   wire  signed [COEF_BITS-1:0] c_im = req_tdata[S0-1:C1];
   wire  signed [SAMPLE_BITS-1:0] s_re = req_tdata[S1-1:S0];
   wire  signed [SAMPLE_BITS-1:0] s_im = req_tdata[S1+SAMPLE_BITS-1:S1];

   wire acc = req_tvalid && req_tready;
   wire is_load = acc && (req_tuser[0] == crfd_pkg::FUNC_LOAD);
   wire is_samp = acc && (req_tuser[0] == crfd_pkg::FUNC_SAMPLE);
   assign req_tready = !busy_ff && !rsp_valid_ff;
   assign csr_ready = 1'b1;

   logic signed [DB-1:0] d_re [MAX_ORDER+1];
   logic signed [DB-1:0] d_im [MAX_ORDER+1];

   logic [5:0] ord;
   always_comb begin
      ord = 6'(order_ff);
      if (ord == 6'd0) ord = 6'd1;
      if (ord > 6'(MAX_ORDER)) ord = 6'(MAX_ORDER);
   end

   assign d_re[MAX_ORDER] = '0;
   assign d_im[MAX_ORDER] = '0;

   // Cell k holds delay k, b[k+1] (none in the last cell) and a[k+1]; b[0] lives in the head here.
   logic signed [COEF_BITS-1:0] b0_re_ff, b0_im_ff;

   for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
      wire bwe = is_load && req_tuser[1] == crfd_pkg::KIND_B && 32'(idx) == k + 1;
      wire awe = is_load && req_tuser[1] == crfd_pkg::KIND_A && 32'(idx) == k + 1;
      crfd_cell #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) u_cell (
         .clock(clock), .reset(reset), .b_we(bwe && k + 1 < MAX_ORDER), .a_we(awe),
         .wr_re(c_re), .wr_im(c_im), .x_re(x_re_ff), .x_im(x_im_ff),
         .y_re(y_re_ff), .y_im(y_im_ff),
         .upd_en(busy_ff && 32'(ord) > k), .is_last(32'(ord) == k + 1),
         .nb_re(d_re[k+1]), .nb_im(d_im[k+1]), .d_re(d_re[k]), .d_im(d_im[k]));
   end

   function automatic logic signed [63:0] rp(input logic signed [PW-1:0] p);
      logic signed [63:0] w;
      w = 64'(p) + (64'sd1 <<< (FRAC_S - 1));
      rp = w >>> FRAC_S;
   endfunction

   function automatic logic signed [OB-1:0] to_out(input logic signed [63:0] v,
                                                    output logic f);
      logic signed [63:0] w;
      logic signed [63:0] hi;
      w = v;
      if (FRAC_C > FRAC_S) w = (v + (64'sd1 <<< (FRAC_C - FRAC_S - 1))) >>> (FRAC_C - FRAC_S);
      else if (FRAC_C < FRAC_S) begin
         if (w > 64'sd33554431) w = 64'sd33554431;
         else if (w < -64'sd33554432) w = -64'sd33554432;
         w = w <<< (FRAC_S - FRAC_C);
      end
      hi = (64'sd1 <<< (OB - 1)) - 64'sd1;
      f = 1'b0;
      if (w > hi) begin f = 1'b1; w = hi; end
      else if (w < -hi - 64'sd1) begin f = 1'b1; w = -hi - 64'sd1; end
      to_out = w[OB-1:0];
   endfunction

   logic signed [63:0] yr_in, yi_in;
   logic signed [OB-1:0] yro, yio;
   logic fr, fi;
   always_comb begin
      yr_in = rp(PW'(b0_re_ff * s_re)) - rp(PW'(b0_im_ff * s_im)) + 64'(d_re[0]);
      yi_in = rp(PW'(b0_re_ff * s_im)) + rp(PW'(b0_im_ff * s_re)) + 64'(d_im[0]);
      yro = to_out(yr_in, fr);
      yio = to_out(yi_in, fi);
   end

   logic [15:0] h;
   logic [16:0] p1;
   logic emit;
   always_comb begin
      h = (hop_ff == 16'd0) ? 16'd1 : hop_ff;
      p1 = 17'(phase_ff) + 17'd1;
      emit = (count_ff != 32'd0) && (p1 >= 17'(h));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 4'd4; hop_ff <= 16'd1; emit_all_ff <= 1'b0;
         count_ff <= '0; phase_ff <= '0; busy_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         b0_re_ff <= '0; b0_im_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               crfd_pkg::CSR_ORDER: order_ff <= csr_data[3:0];
               crfd_pkg::CSR_HOP:   hop_ff <= csr_data;
               crfd_pkg::CSR_EMIT:  emit_all_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (is_load && req_tuser[1] == crfd_pkg::KIND_B && idx == 4'd0) begin
            b0_re_ff <= c_re; b0_im_ff <= c_im;
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         busy_ff <= is_samp;
         if (is_samp) begin
            x_re_ff <= s_re; x_im_ff <= s_im;
            y_re_ff <= yro; y_im_ff <= yio;
            if (count_ff == 32'd0) phase_ff <= '0;
            else phase_ff <= emit ? 16'd0 : p1[15:0];
            count_ff <= count_ff + 32'd1;
            if (emit || emit_all_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff <= {count_ff + 32'd1, 24'(yio), 24'(yro)};
               rsp_user_ff <= fr | fi;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_NEXT(a_busy_one, clock, reset, is_samp, busy_ff && !req_tready)
   `ASSERT_IMPLIES(a_no_acc_busy, clock, reset, busy_ff, !acc)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_tready, rsp_valid_ff && $stable(rsp_data_ff))
endmodule

// ----- hw/rtl/crfd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfd_cell
// One delay stage: holds its coefficients and delay word, and forms the new
// delay from the neighbour's value, the sample and the fed-back output (the last stage from the fed-back output alone).
// ----------------------------------------------------------------------------
module crfd_cell #(
   parameter int SAMPLE_BITS = crfd_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = crfd_pkg::COEF_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   b_we,
   input  logic                                   a_we,
   input  logic signed [COEF_BITS-1:0]            wr_re,
   input  logic signed [COEF_BITS-1:0]            wr_im,
   input  logic signed [SAMPLE_BITS-1:0]          x_re,
   input  logic signed [SAMPLE_BITS-1:0]          x_im,
   input  logic signed [crfd_pkg::OUT_BITS-1:0]   y_re,
   input  logic signed [crfd_pkg::OUT_BITS-1:0]   y_im,
   input  logic                                   upd_en,
   input  logic                                   is_last,
   input  logic signed [crfd_pkg::DELAY_BITS-1:0] nb_re,
   input  logic signed [crfd_pkg::DELAY_BITS-1:0] nb_im,
   output logic signed [crfd_pkg::DELAY_BITS-1:0] d_re,
   output logic signed [crfd_pkg::DELAY_BITS-1:0] d_im
);
   localparam int FRAC_S = SAMPLE_BITS - 1;
   localparam int PW     = COEF_BITS +
                           (SAMPLE_BITS > crfd_pkg::OUT_BITS ? SAMPLE_BITS : crfd_pkg::OUT_BITS);

   logic signed [COEF_BITS-1:0] b_re_ff, b_im_ff, a_re_ff, a_im_ff;
   logic signed [crfd_pkg::DELAY_BITS-1:0] d_re_ff, d_im_ff;
   logic signed [63:0] ff_re_in, ff_im_in, nr_in, ni_in;

   function automatic logic signed [63:0] rp(input logic signed [PW-1:0] p);
      logic signed [63:0] w;
      w = 64'(p) + (64'sd1 <<< (FRAC_S - 1));
      rp = w >>> FRAC_S;
   endfunction

   always_comb begin
      ff_re_in = rp(PW'(b_re_ff * x_re)) - rp(PW'(b_im_ff * x_im));
      ff_im_in = rp(PW'(b_re_ff * x_im)) + rp(PW'(b_im_ff * x_re));
      nr_in = (is_last ? 64'sd0 : 64'(nb_re) + ff_re_in)
              - (rp(PW'(a_re_ff * y_re)) - rp(PW'(a_im_ff * y_im)));
      ni_in = (is_last ? 64'sd0 : 64'(nb_im) + ff_im_in)
              - (rp(PW'(a_re_ff * y_im)) + rp(PW'(a_im_ff * y_re)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_re_ff <= '0; b_im_ff <= '0; a_re_ff <= '0; a_im_ff <= '0;
         d_re_ff <= '0; d_im_ff <= '0;
      end else begin
         if (b_we) begin b_re_ff <= wr_re; b_im_ff <= wr_im; end
         if (a_we) begin a_re_ff <= wr_re; a_im_ff <= wr_im; end
         if (upd_en) begin
            d_re_ff <= crfd_pkg::sat_delay(nr_in);
            d_im_ff <= crfd_pkg::sat_delay(ni_in);
         end
      end
   end

   assign d_re = d_re_ff;
   assign d_im = d_im_ff;
endmodule

// ----- tb/complex_recursive_filter_decimating_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_recursive_filter_decimating_tb
// Self-checking bench for the complex IIR filter with decimation. It runs a
// short table of directed words and then random phases, each phase possibly with
// a new order, hop and emit setting, then coefficient loads and a burst of samples.
// A local fixed-point model predicts every filtered sample; typed directed words give their own.
// ----------------------------------------------------------------------------
module complex_recursive_filter_decimating_tb;

   localparam int REQ_W = 88;
   localparam int SETTLE_CYCLES = 12;

   typedef struct {
      crfd_pkg::func_type func;
      crfd_pkg::kind_type kind;
      logic [3:0]  idx;
      logic [23:0] cre;
      logic [23:0] cim;
      logic [15:0] sre;
      logic [15:0] sim;
      bit          typed;
      logic [23:0] tre;
      logic [23:0] tim;
   } filt_word_type;

   typedef struct {
      logic [23:0] re;
      logic [23:0] im;
      bit          sat;
      logic [31:0] cnt;
   } filt_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   complex_recursive_filter_decimating u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Filter model state.
   longint dly_re [8];
   longint dly_im [8];
   longint b_re [8];
   longint b_im [8];
   longint a_re [8];
   longint a_im [8];
   logic [31:0] n_samples;
   logic [15:0] phase;
   logic [3:0] cfg_order;
   logic [15:0] cfg_hop;
   bit cfg_emit;

   filt_out_type pending_outputs[$];
   int errors = 0;
   int n_results = 0;
   int n_sat = 0;
   int n_words = 0;
   bit calm = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic longint mul_round(input longint c, input longint x);
      return (c * x + 64'sd16384) >>> 15;
   endfunction

   function automatic longint clip(input longint v, input int bits, inout bit f);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (v > hi) begin
         f = 1'b1;
         return hi;
      end
      if (v < -hi - 1) begin
         f = 1'b1;
         return -hi - 1;
      end
      return v;
   endfunction

   function automatic void model_reset();
      for (int i = 0; i < 8; i++) begin
         dly_re[i] = 0; dly_im[i] = 0;
         b_re[i] = 0; b_im[i] = 0;
         a_re[i] = 0; a_im[i] = 0;
      end
      n_samples = '0;
      phase = '0;
      cfg_order = 4'd4;
      cfg_hop = 16'd1;
      cfg_emit = 1'b0;
   endfunction

   // Applies one accepted word to the model; returns 1 when a result is due.
   function automatic bit filter_word(input filt_word_type w, output filt_out_type r);
      int ord;
      logic [15:0] h;
      logic [16:0] p;
      logic [2:0] ai;
      longint xr, xi, yr, yi, nr, ni, cr, ci;
      bit f, dummy, due;
      r = '{default: '0};
      if (w.func == crfd_pkg::FUNC_LOAD) begin
         cr = longint'($signed(w.cre));
         ci = longint'($signed(w.cim));
         if (w.kind == crfd_pkg::KIND_B) begin
            if (w.idx < 8) begin
               b_re[w.idx[2:0]] = cr; b_im[w.idx[2:0]] = ci;
            end
         end else if (w.idx >= 1 && w.idx <= 8) begin
            ai = 3'(w.idx - 4'd1);
            a_re[ai] = cr; a_im[ai] = ci;
         end
         return 1'b0;
      end
      ord = (cfg_order == 0) ? 1 : (cfg_order > 8 ? 8 : int'(cfg_order));
      h = (cfg_hop == 0) ? 16'd1 : cfg_hop;
      xr = longint'($signed(w.sre));
      xi = longint'($signed(w.sim));
      f = 1'b0;
      dummy = 1'b0;
      yr = mul_round(b_re[0], xr) - mul_round(b_im[0], xi) + dly_re[0];
      yi = mul_round(b_re[0], xi) + mul_round(b_im[0], xr) + dly_im[0];
      yr = clip((yr + 16) >>> 5, 24, f);
      yi = clip((yi + 16) >>> 5, 24, f);
      for (int n = 0; n < ord - 1; n++) begin
         nr = dly_re[n + 1] + mul_round(b_re[n + 1], xr) - mul_round(b_im[n + 1], xi)
            - (mul_round(a_re[n], yr) - mul_round(a_im[n], yi));
         ni = dly_im[n + 1] + mul_round(b_re[n + 1], xi) + mul_round(b_im[n + 1], xr)
            - (mul_round(a_re[n], yi) + mul_round(a_im[n], yr));
         dly_re[n] = clip(nr, 40, dummy);
         dly_im[n] = clip(ni, 40, dummy);
      end
      dly_re[ord - 1] = clip(-(mul_round(a_re[ord - 1], yr) - mul_round(a_im[ord - 1], yi)),
                             40, dummy);
      dly_im[ord - 1] = clip(-(mul_round(a_re[ord - 1], yi) + mul_round(a_im[ord - 1], yr)),
                             40, dummy);
      due = 1'b0;
      if (n_samples == 0) begin
         phase = '0;
      end else begin
         p = {1'b0, phase} + 17'd1;
         if (p >= {1'b0, h}) begin
            p = '0;
            due = 1'b1;
         end
         phase = p[15:0];
      end
      n_samples = n_samples + 32'd1;
      r.re = yr[23:0];
      r.im = yi[23:0];
      r.sat = f;
      r.cnt = n_samples;
      return due || cfg_emit;
   endfunction

   function automatic int gap_len();
      int k;
      if (calm) return 0;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: random back-pressure, decided at each rising edge.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (gap_len() == 0);
   end

   // Result checker: looks at the handshake on the falling edge, ahead of the rising edge that takes it.
   always @(negedge clock) begin
      filt_out_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (rsp_tuser) n_sat++;
         if (pending_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %h", rsp_tdata));
         end else begin
            e = pending_outputs.pop_front();
            if (rsp_tdata[23:0] !== e.re)
               report_mismatch($sformatf("out_re %h, want %h", rsp_tdata[23:0], e.re));
            if (rsp_tdata[47:24] !== e.im)
               report_mismatch($sformatf("out_im %h, want %h", rsp_tdata[47:24], e.im));
            if (rsp_tuser !== e.sat)
               report_mismatch($sformatf("saturated %b, want %b", rsp_tuser, e.sat));
            if (rsp_tdata[79:48] !== e.cnt)
               report_mismatch($sformatf("count %0d, want %0d", rsp_tdata[79:48], e.cnt));
         end
      end
   end

   task automatic send_word(input filt_word_type w);
      int g;
      filt_out_type r;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {w.kind, w.func};
      req_tdata <= {4'd0, w.sim, w.sre, w.cim, w.cre, w.idx};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      n_words++;
      if (filter_word(w, r)) begin
         if (w.typed) begin
            r.re = w.tre;
            r.im = w.tim;
         end
         pending_outputs.push_back(r);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         crfd_pkg::CSR_ORDER: cfg_order = val[3:0];
         crfd_pkg::CSR_HOP:   cfg_hop = val;
         crfd_pkg::CSR_EMIT:  cfg_emit = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic filt_word_type mk_load(input crfd_pkg::kind_type k, input logic [3:0] i,
                                             input logic [23:0] re, input logic [23:0] im);
      filt_word_type w;
      w = '{func: crfd_pkg::FUNC_LOAD, kind: crfd_pkg::KIND_B, default: '0};
      w.kind = k;
      w.idx = i;
      w.cre = re;
      w.cim = im;
      w.sre = 16'($urandom());
      w.sim = 16'($urandom());
      return w;
   endfunction

   function automatic filt_word_type mk_sample(input logic [15:0] re, input logic [15:0] im);
      filt_word_type w;
      w = '{func: crfd_pkg::FUNC_SAMPLE, kind: crfd_pkg::KIND_B, default: '0};
      w.kind = crfd_pkg::kind_type'($urandom_range(0, 1));
      w.idx = 4'($urandom());
      w.cre = 24'($urandom());
      w.cim = 24'($urandom());
      w.sre = re;
      w.sim = im;
      return w;
   endfunction

   function automatic filt_word_type mk_typed(input logic [15:0] re, input logic [15:0] im,
                                              input logic [23:0] tre, input logic [23:0] tim);
      filt_word_type w;
      w = mk_sample(re, im);
      w.typed = 1'b1;
      w.tre = tre;
      w.tim = tim;
      return w;
   endfunction

   // Coefficient value: mostly small enough for a stable loop, some full range.
   function automatic logic [23:0] rand_coef();
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) return 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      if (k < 8) return 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      return 24'($urandom());
   endfunction

   initial begin
      filt_word_type directed[$];
      filt_word_type w;
      int orders[$];
      int phase_no, burst;
      orders = '{1, 8, 0, 15, 9, 3};
      model_reset();
      // Reset values: order 4, hop 1, no emit-all, zero coefficients.
      directed.push_back(mk_sample(16'h7fff, 16'h8000));          // n = 0, no result
      directed.push_back(mk_typed(16'h1234, 16'h8000, 24'd0, 24'd0));
      directed.push_back(mk_load(crfd_pkg::KIND_B, 4'd0, 24'h100000, 24'h000000)); // b0 = 1
      directed.push_back(mk_typed(16'h7fff, 16'h8000, 24'h007fff, 24'hff8000));
      directed.push_back(mk_typed(16'h8000, 16'h7fff, 24'hff8000, 24'h007fff));
      directed.push_back(mk_load(crfd_pkg::KIND_A, 4'd0, 24'h7fffff, 24'h7fffff)); // a0 ignored
      directed.push_back(mk_load(crfd_pkg::KIND_B, 4'd8, 24'h7fffff, 24'h800000)); // out of range
      directed.push_back(mk_load(crfd_pkg::KIND_B, 4'd15, 24'h800000, 24'h7fffff));
      directed.push_back(mk_load(crfd_pkg::KIND_A, 4'd9, 24'h800000, 24'h800000));
      directed.push_back(mk_load(crfd_pkg::KIND_A, 4'd15, 24'h7fffff, 24'h7fffff));
      directed.push_back(mk_typed(16'h0000, 16'h0000, 24'd0, 24'd0));
      directed.push_back(mk_load(crfd_pkg::KIND_B, 4'd1, 24'h7fffff, 24'h800000));
      directed.push_back(mk_load(crfd_pkg::KIND_A, 4'd1, 24'h800000, 24'h7fffff));
      directed.push_back(mk_load(crfd_pkg::KIND_A, 4'd4, 24'h7fffff, 24'h800000));
      directed.push_back(mk_load(crfd_pkg::KIND_A, 4'd8, 24'h400000, 24'h000001));
      directed.push_back(mk_load(crfd_pkg::KIND_B, 4'd7, 24'h800000, 24'h800000));
      directed.push_back(mk_load(crfd_pkg::KIND_B, 4'd0, 24'h7fffff, 24'h7fffff)); // b0 near 8
      for (int i = 0; i < 8; i++)
         directed.push_back(mk_sample(i[0] ? 16'h7fff : 16'h8000, i[1] ? 16'h8000 : 16'h7fff));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_word(directed[i]);

      phase_no = 0;
      while (n_words < 1230) begin
         // Every setting change waits until the filter has drained.
         wait_idle();
         calm = ($urandom_range(0, 4) == 0);
         if (phase_no < orders.size())
            csr_write(crfd_pkg::CSR_ORDER, 16'(orders[phase_no]));
         else if ($urandom_range(0, 1))
            csr_write(crfd_pkg::CSR_ORDER, 16'($urandom_range(0, 15)) | 16'hfff0);
         case (phase_no)
            0: csr_write(crfd_pkg::CSR_HOP, 16'd0);
            1: csr_write(crfd_pkg::CSR_HOP, 16'hffff);
            2: csr_write(crfd_pkg::CSR_HOP, 16'd3);
            default:
               if ($urandom_range(0, 1)) begin
                  if ($urandom_range(0, 9) == 0)
                     csr_write(crfd_pkg::CSR_HOP, 16'($urandom()));
                  else
                     csr_write(crfd_pkg::CSR_HOP, 16'($urandom_range(1, 6)));
               end
         endcase
         if (phase_no < 2 || $urandom_range(0, 2) == 0)
            csr_write(crfd_pkg::CSR_EMIT, (phase_no == 1 || cfg_hop > 16'd16) ? 16'hffff
                      : 16'($urandom_range(0, 1)) | 16'h5a5a & 16'hfffe);
         else if (cfg_hop > 16'd16 && !cfg_emit)
            csr_write(crfd_pkg::CSR_EMIT, 16'd1);
         // Fresh coefficient set, then a sample burst with a little noise.
         for (int i = 0; i < 8; i++) begin
            send_word(mk_load(crfd_pkg::KIND_B, 4'(i), rand_coef(), rand_coef()));
            send_word(mk_load(crfd_pkg::KIND_A, 4'(i + 1), rand_coef(), rand_coef()));
         end
         burst = $urandom_range(20, 60);
         for (int i = 0; i < burst; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               w = mk_load(crfd_pkg::kind_type'($urandom_range(0, 1)), 4'($urandom()),
                           24'($urandom()), 24'($urandom()));
               w.func = crfd_pkg::func_type'($urandom_range(0, 1));
               send_word(w);
            end else if ($urandom_range(0, 3) == 0) begin
               send_word(mk_sample(16'($urandom()), 16'($urandom())));
            end else begin
               send_word(mk_sample(16'($signed($urandom_range(0, 8191)) - 4096),
                                   16'($signed($urandom_range(0, 8191)) - 4096)));
            end
         end
         phase_no++;
      end
      wait_idle();
      repeat (20) @(posedge clock);
      $display("Ran %0d input words over %0d setting phases.", n_words, phase_no);
      $display("Checked %0d filtered samples, %0d of them clipped.", n_results, n_sat);
      if (errors == 0 && pending_outputs.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Timed out with %0d results outstanding.", pending_outputs.size());
      $display("simulation failed");
      $finish;
   end
endmodule
